// File: sv/k_queues_shared_buffer_assert.svh
// Assertion macros for the shared-buffer queue block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef K_QUEUES_SHARED_BUFFER_ASSERT_SVH
`define K_QUEUES_SHARED_BUFFER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge outside reset
`define KQSB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition must never be true outside reset
`define KQSB_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define KQSB_ASSERT(label, clk, rstn, prop, msg)
`define KQSB_ASSERT_NEVER(label, clk, rstn, cond, msg)
`endif
`endif

// File: sv/kqsb_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the shared-buffer queue block.
// No dependencies; imported by every module of the block.
package kqsb_pkg;

    localparam int DEF_NUM_QUEUES = 4;
    localparam int DEF_NUM_SLOTS  = 16;
    localparam int DATA_W         = 32;
    localparam int QNUM_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int S_TUSER_W      = 1 + QNUM_W;

    typedef enum logic {
        FUNC_ENQ = 1'b0,
        FUNC_DEQ = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    // queue table strobes
    typedef struct packed {
        logic rd;
        logic wr;
        logic set_live;
        logic clr_live;
    } qt_ctrl_t;

    // slot store strobes
    typedef struct packed {
        logic rd;
        logic data_wr;
        logic link_wr;
    } slot_ctrl_t;

    // Reduce a queue number modulo count by repeated subtraction (narrow input).
    function automatic logic [QNUM_W-1:0] queue_wrap(input logic [QNUM_W-1:0] num,
                                                     input int unsigned count);
        logic [QNUM_W-1:0] r;
        r = num;
        for (int i = 0; i < (1 << QNUM_W) - 1; i++) begin
            if (int'(r) >= int'(count)) begin
                r = QNUM_W'(int'(r) - int'(count));
            end
        end
        return r;
    endfunction

endpackage

// File: sv/kqsb_queue_table.sv
`timescale 1ns / 1ps
// Per-queue head/tail memory plus a live (non-empty) flag for each queue.
// Depends on kqsb_pkg for the control struct.
module kqsb_queue_table import kqsb_pkg::*; #(
    parameter int NUM_QUEUES = DEF_NUM_QUEUES,
    parameter int SLOT_W     = 4,
    parameter int QUEUE_W    = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  qt_ctrl_t          ctrl,
    input  logic [QUEUE_W-1:0] addr,
    input  logic [SLOT_W-1:0] wr_head,
    input  logic [SLOT_W-1:0] wr_tail,
    output logic [SLOT_W-1:0] rd_head,
    output logic [SLOT_W-1:0] rd_tail,
    output logic              rd_live
);

    logic [2*SLOT_W-1:0]   ptr_mem [NUM_QUEUES];
    logic [2*SLOT_W-1:0]   rd_ptrs_reg;
    logic [NUM_QUEUES-1:0] live_reg;
    logic                  rd_live_reg;

    // head/tail store, registered read
    always_ff @(posedge aclk) begin
        if (ctrl.wr) begin
            ptr_mem[addr] <= {wr_head, wr_tail};
        end
        if (ctrl.rd) begin
            rd_ptrs_reg <= ptr_mem[addr];
        end
    end

    // live flags stand in for the null head at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg    <= '0;
            rd_live_reg <= 1'b0;
        end else begin
            if (ctrl.set_live) begin
                live_reg[addr] <= 1'b1;
            end
            if (ctrl.clr_live) begin
                live_reg[addr] <= 1'b0;
            end
            if (ctrl.rd) begin
                rd_live_reg <= live_reg[addr];
            end
        end
    end

    assign rd_head = rd_ptrs_reg[2*SLOT_W-1:SLOT_W];
    assign rd_tail = rd_ptrs_reg[SLOT_W-1:0];
    assign rd_live = rd_live_reg;

endmodule

// File: sv/kqsb_slot_mem.sv
`timescale 1ns / 1ps
// Slot store: value memory and next-link memory with a fill count for link reset.
// Depends on kqsb_pkg and the assertion macro header.
`include "k_queues_shared_buffer_assert.svh"
module kqsb_slot_mem import kqsb_pkg::*; #(
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int SLOT_W    = 4,
    parameter int LINK_W    = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  slot_ctrl_t        ctrl,
    input  logic [SLOT_W-1:0] rd_addr,
    input  logic [SLOT_W-1:0] data_wr_addr,
    input  logic [SLOT_W-1:0] link_wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [LINK_W-1:0] wr_link,
    output logic [DATA_W-1:0] rd_data,
    output logic [LINK_W-1:0] rd_link
);

    logic [DATA_W-1:0] data_mem [NUM_SLOTS];
    logic [LINK_W-1:0] link_mem [NUM_SLOTS];

    logic [DATA_W-1:0] rd_data_reg;
    logic [LINK_W-1:0] link_q_reg;
    logic [LINK_W-1:0] fresh_link_reg;
    logic              fresh_reg;
    logic [LINK_W-1:0] fill_reg;
    logic [LINK_W-1:0] fill_next;

    // Slots at or above the fill count were never taken; their link is slot + 1,
    // and the free list always hands them out in ascending order.
    always_comb begin
        fill_next = fill_reg;
        if (ctrl.data_wr && LINK_W'(data_wr_addr) == fill_reg) begin
            fill_next = fill_reg + LINK_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg  <= '0;
            fresh_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (ctrl.rd) begin
                fresh_reg <= (LINK_W'(rd_addr) == fill_reg);
            end
        end
    end

    // memories, registered read
    always_ff @(posedge aclk) begin
        if (ctrl.data_wr) begin
            data_mem[data_wr_addr] <= wr_data;
        end
        if (ctrl.link_wr) begin
            link_mem[link_wr_addr] <= wr_link;
        end
        if (ctrl.rd) begin
            rd_data_reg    <= data_mem[rd_addr];
            link_q_reg     <= link_mem[rd_addr];
            fresh_link_reg <= LINK_W'(rd_addr) + LINK_W'(1);
        end
    end

    assign rd_data = rd_data_reg;
    assign rd_link = fresh_reg ? fresh_link_reg : link_q_reg;

    `KQSB_ASSERT_NEVER(a_fill_bound, aclk, aresetn, fill_reg > LINK_W'(NUM_SLOTS), "fill count past store size")
    `KQSB_ASSERT(a_data_wr_frontier, aclk, aresetn, ctrl.data_wr |-> LINK_W'(data_wr_addr) <= fill_reg, "value written beyond fill frontier")
    `KQSB_ASSERT(a_link_wr_taken, aclk, aresetn, ctrl.link_wr |-> LINK_W'(link_wr_addr) < fill_reg, "link written to a slot never taken")

endmodule

// File: sv/k_queues_shared_buffer.sv
`timescale 1ns / 1ps
// Top level: several FIFO queues in one shared slot store with a free list.
// Depends on kqsb_pkg, kqsb_slot_mem, kqsb_queue_table and the assertion header.
//
//  channel | direction | tdata          | tuser (low bit up)
//  s_      | in        | value_in [31:0]| func [0], queue_num [2:1]
//  m_      | out       | value_out[31:0]| status [1:0]
//
// Enqueue, overflow and underflow finish after the queue table read; a successful
// dequeue also waits for the slot store read that follows the queue table read.
// One transaction is in flight at a time; s_tready is high only when idle.
// A finished result waits in the output register; a stall on m_ holds the
// operation before any state is written. Reset is immediate, no clearing pass.
`include "k_queues_shared_buffer_assert.svh"
module k_queues_shared_buffer import kqsb_pkg::*; #(
    parameter int NUM_QUEUES = DEF_NUM_QUEUES,
    parameter int NUM_SLOTS  = DEF_NUM_SLOTS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // value_in
    input  logic [S_TUSER_W-1:0] s_tuser,   // func, queue_num
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // value_out
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int LINK_W  = $clog2(NUM_SLOTS + 1);
    localparam int QUEUE_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_SLOTS);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOOK = 3'b010,
        ST_READ = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    func_t               op_reg;
    logic [QUEUE_W-1:0]  q_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [LINK_W-1:0]   free_reg, free_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [DATA_W-1:0]   m_data_reg, m_data_next;

    logic                s_accept;
    logic                out_free;
    logic [QUEUE_W-1:0]  q_in;

    qt_ctrl_t            qt_ctrl;
    logic [QUEUE_W-1:0]  qt_addr;
    logic [SLOT_W-1:0]   qt_wr_head, qt_wr_tail;
    logic [SLOT_W-1:0]   rd_head, rd_tail;
    logic                rd_live;

    slot_ctrl_t          slot_ctrl;
    logic [SLOT_W-1:0]   slot_rd_addr;
    logic [SLOT_W-1:0]   link_wr_addr;
    logic [DATA_W-1:0]   rd_data;
    logic [LINK_W-1:0]   rd_link;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign q_in     = QUEUE_W'(queue_wrap(s_tuser[S_TUSER_W-1:1], NUM_QUEUES));

    // addresses follow the phase of the operation
    assign qt_addr      = (state_reg == ST_IDLE) ? q_in : q_reg;
    assign slot_rd_addr = (state_reg == ST_IDLE) ? free_reg[SLOT_W-1:0] : rd_head;
    assign link_wr_addr = (state_reg == ST_READ) ? rd_head : rd_tail;
    assign qt_wr_head   = (state_reg == ST_READ) ? rd_link[SLOT_W-1:0]
                        : (rd_live ? rd_head : free_reg[SLOT_W-1:0]);
    assign qt_wr_tail   = (state_reg == ST_READ) ? rd_tail : free_reg[SLOT_W-1:0];

    // sequencer: lookup, optional slot read, then read-modify-write commit
    always_comb begin
        state_next    = state_reg;
        free_next     = free_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_data_next   = m_data_reg;
        qt_ctrl       = '0;
        slot_ctrl     = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    qt_ctrl.rd   = 1'b1;
                    slot_ctrl.rd = 1'b1;
                    state_next   = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (op_reg == FUNC_ENQ) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next  = '0;
                        state_next   = ST_IDLE;
                        if (free_reg == NIL) begin
                            m_status_next = STATUS_OVERFLOW;
                        end else begin
                            m_status_next     = STATUS_OK;
                            slot_ctrl.data_wr = 1'b1;
                            slot_ctrl.link_wr = rd_live;
                            qt_ctrl.wr        = 1'b1;
                            qt_ctrl.set_live  = 1'b1;
                            free_next         = rd_link;
                        end
                    end
                end else if (!rd_live) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_status_next = STATUS_UNDERFLOW;
                        m_data_next   = '0;
                        state_next    = ST_IDLE;
                    end
                end else begin
                    slot_ctrl.rd = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = STATUS_OK;
                    m_data_next       = rd_data;
                    qt_ctrl.wr        = 1'b1;
                    qt_ctrl.clr_live  = (rd_head == rd_tail);
                    slot_ctrl.link_wr = 1'b1;
                    free_next         = LINK_W'(rd_head);
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            free_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg  <= func_t'(s_tuser[0]);
            q_reg   <= q_in;
            val_reg <= s_tdata;
        end
        m_status_reg <= m_status_next;
        m_data_reg   <= m_data_next;
    end

    kqsb_slot_mem #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_W    (SLOT_W),
        .LINK_W    (LINK_W)
    ) u_slot_mem (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (slot_ctrl),
        .rd_addr      (slot_rd_addr),
        .data_wr_addr (free_reg[SLOT_W-1:0]),
        .link_wr_addr (link_wr_addr),
        .wr_data      (val_reg),
        .wr_link      (free_reg),
        .rd_data      (rd_data),
        .rd_link      (rd_link)
    );

    kqsb_queue_table #(
        .NUM_QUEUES (NUM_QUEUES),
        .SLOT_W     (SLOT_W),
        .QUEUE_W    (QUEUE_W)
    ) u_queue_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (qt_ctrl),
        .addr    (qt_addr),
        .wr_head (qt_wr_head),
        .wr_tail (qt_wr_tail),
        .rd_head (rd_head),
        .rd_tail (rd_tail),
        .rd_live (rd_live)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    `KQSB_ASSERT(a_accept_to_look, aclk, aresetn, s_accept |=> state_reg == ST_LOOK, "accepted transaction did not start lookup")
    `KQSB_ASSERT(a_read_is_dequeue, aclk, aresetn, state_reg == ST_READ |-> op_reg == FUNC_DEQ && rd_live, "slot read phase without a live dequeue")
    `KQSB_ASSERT(a_result_source, aclk, aresetn, $rose(m_tvalid) |-> $past(state_reg) == ST_LOOK || $past(state_reg) == ST_READ, "result raised outside a commit phase")
    `KQSB_ASSERT_NEVER(a_free_range, aclk, aresetn, free_reg > NIL, "free list head out of range")

endmodule

// File: test/tb_k_queues_shared_buffer.sv
`timescale 1ns / 1ps
// Self-checking bench for k_queues_shared_buffer: a stream driver and a result monitor,
// with a predictor of the shared slot store. Depends on kqsb_pkg and the RTL.
module tb_k_queues_shared_buffer;
    import kqsb_pkg::*;

    localparam int NUM_QUEUES  = DEF_NUM_QUEUES;
    localparam int NUM_SLOTS   = DEF_NUM_SLOTS;
    localparam int LINK_W      = $clog2(NUM_SLOTS + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_SLOTS);
    localparam int RANDOM_OPS  = 1700;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        func_t             func;
        logic [QNUM_W-1:0] qnum;
        logic [DATA_W-1:0] value;
    } queue_op_t;

    typedef struct {
        status_t           status;
        logic [DATA_W-1:0] value;
    } op_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata  = '0;   // value_in
    logic [S_TUSER_W-1:0] s_tuser  = '0;   // func, queue_num
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_W-1:0]    m_tdata;         // value_out
    logic [STATUS_W-1:0]  m_tuser;         // status

    k_queues_shared_buffer #(
        .NUM_QUEUES(NUM_QUEUES),
        .NUM_SLOTS (NUM_SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus and expectations
    queue_op_t  op_backlog[$];
    op_result_t results_due[$];
    int         total_ops;
    int         ops_sent     = 0;
    int         results_seen = 0;
    int         mismatches   = 0;
    int         cycle_count  = 0;
    bit         calm         = 1'b0;

    // predictor copy of the store
    logic [DATA_W-1:0] slot_val [NUM_SLOTS];
    logic [LINK_W-1:0] slot_next[NUM_SLOTS];
    logic [LINK_W-1:0] q_first  [NUM_QUEUES];
    logic [LINK_W-1:0] q_last   [NUM_QUEUES];
    logic [LINK_W-1:0] free_first;
    int n_enq = 0, n_deq = 0, n_overflow = 0, n_underflow = 0;

    // occupancy as seen by the generator, kept up to date by add_op
    int gen_fill[NUM_QUEUES];
    int gen_total;

    function automatic void clear_store();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_val[i]  = '0;
            slot_next[i] = LINK_W'(i + 1);
        end
        for (int i = 0; i < NUM_QUEUES; i++) begin
            q_first[i] = NIL;
            q_last[i]  = '0;
        end
        free_first = '0;
    endfunction

    // Apply one accepted operation to the store copy and queue its result.
    function automatic void apply_queue_op(input queue_op_t op);
        op_result_t        r;
        int                q;
        logic [LINK_W-1:0] s;
        r.status = STATUS_OK;
        r.value  = '0;
        q = int'(op.qnum) % NUM_QUEUES;
        if (op.func == FUNC_ENQ) begin
            if (free_first == NIL) begin
                r.status = STATUS_OVERFLOW;
                n_overflow++;
            end else begin
                s          = free_first;
                free_first = slot_next[s];
                if (q_first[q] == NIL)
                    q_first[q] = s;
                else
                    slot_next[q_last[q]] = s;
                slot_next[s] = NIL;
                q_last[q]    = s;
                slot_val[s]  = op.value;
                n_enq++;
            end
        end else begin
            if (q_first[q] == NIL) begin
                r.status = STATUS_UNDERFLOW;
                n_underflow++;
            end else begin
                s            = q_first[q];
                r.value      = slot_val[s];
                q_first[q]   = slot_next[s];
                slot_next[s] = free_first;
                free_first   = s;
                n_deq++;
            end
        end
        results_due.push_back(r);
    endfunction

    function automatic void add_op(input func_t f, input int q, input logic [DATA_W-1:0] v);
        queue_op_t op;
        op.func  = f;
        op.qnum  = QNUM_W'(q);
        op.value = v;
        op_backlog.push_back(op);
        if (f == FUNC_ENQ && gen_total < NUM_SLOTS) begin
            gen_fill[q]++;
            gen_total++;
        end else if (f == FUNC_DEQ && gen_fill[q] > 0) begin
            gen_fill[q]--;
            gen_total--;
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] corner[6];
        corner = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1, 32'hffff_fffe};
        if ($urandom_range(0, 7) == 0)
            return corner[$urandom_range(0, 5)];
        return $urandom();
    endfunction

    // mostly short idles, a few long ones
    function automatic int draw_pause(input bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatches++;
        $display("ERROR result %0d: %s got 0x%08h, want 0x%08h", results_seen, field, got, want);
    endtask

    // Stimulus: directed corners, then phases with a varying enqueue bias.
    function automatic void build_stimulus();
        logic [DATA_W-1:0] fill_vals[8];
        int made, span, bias, focus;
        fill_vals = '{32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h5555_5555,
                      32'haaaa_aaaa, 32'h7fff_ffff, 32'h1, 32'hffff_fffe};
        for (int i = 0; i < NUM_QUEUES; i++)
            gen_fill[i] = 0;
        gen_total = 0;

        // empty queue at reset, single round trip, then empty again
        add_op(FUNC_DEQ, 0, 32'h1234_5678);
        add_op(FUNC_ENQ, 0, 32'h7fff_ffff);
        add_op(FUNC_DEQ, 0, 32'h0);
        add_op(FUNC_DEQ, 0, 32'hffff_ffff);
        // fill the whole store across all queues, then overflow
        for (int i = 0; i < NUM_SLOTS; i++)
            add_op(FUNC_ENQ, i % NUM_QUEUES, fill_vals[i % 8] ^ DATA_W'(i >> 3));
        add_op(FUNC_ENQ, 3, 32'hdead_beef);
        for (int q = NUM_QUEUES - 1; q >= 0; q--)
            add_op(FUNC_DEQ, q, 32'hffff_ffff);

        made = 0;
        while (made < RANDOM_OPS) begin
            span = $urandom_range(20, 60);
            case ($urandom_range(0, 3))
                0: bias = 15;
                1: bias = 50;
                2: bias = 85;
                default: bias = 97;
            endcase
            focus = ($urandom_range(0, 1) == 0) ? -1 : int'($urandom_range(0, NUM_QUEUES - 1));
            for (int k = 0; k < span && made < RANDOM_OPS; k++) begin
                add_op(($urandom_range(0, 99) < bias) ? FUNC_ENQ : FUNC_DEQ,
                       (focus < 0 || $urandom_range(0, 4) == 0)
                           ? int'($urandom_range(0, NUM_QUEUES - 1)) : focus,
                       pick_value());
                made++;
            end
        end
        total_ops = op_backlog.size();
    endfunction

    always @(posedge aclk)
        cycle_count <= cycle_count + 1;

    // Driver: presents the backlog, predicts on each accepted transaction.
    int        send_pause;
    queue_op_t cur_op;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            send_pause = draw_pause(1'b0);
        end else begin
            if (s_tvalid && s_tready) begin
                apply_queue_op(cur_op);
                ops_sent++;
                if (ops_sent % 64 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_pause = draw_pause(calm);
            end
            if (!s_tvalid || s_tready) begin
                if (send_pause > 0) begin
                    send_pause--;
                    s_tvalid <= 1'b0;
                end else if (op_backlog.size() > 0) begin
                    cur_op = op_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_op.value;
                    s_tuser  <= {cur_op.qnum, cur_op.func};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, checks each result transaction in order.
    int         stall_left;
    op_result_t want;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected transaction", m_tdata, '0);
                end else begin
                    want = results_due.pop_front();
                    if (m_tuser !== want.status)
                        report_mismatch("status", DATA_W'(m_tuser), DATA_W'(want.status));
                    if (m_tdata !== want.value)
                        report_mismatch("value_out", m_tdata, want.value);
                end
                results_seen++;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = draw_pause(1'b0);
            end
        end
    end

    // Watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, results_due.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        clear_store();
        build_stimulus();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (ops_sent < total_ops)
            @(posedge aclk);
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Ran %0d operations: %0d enqueues, %0d dequeues, %0d overflows, %0d underflows",
                 total_ops, n_enq, n_deq, n_overflow, n_underflow);
        $display("Checked %0d result transactions, %0d field errors", results_seen, mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
